// File: sv/sqwsd_pkg.sv
// ----------------------------------------------------------------------------
// sqwsd_pkg
// Shared sizes, codes and helpers of the shortest-queue dispatcher.
// ----------------------------------------------------------------------------
package sqwsd_pkg;

    localparam int NUM_WORKERS = 4;
    localparam int QUEUE_DEPTH = 16;
    localparam int HANDLE_BITS = 10;

    // fixed field widths of the ports
    localparam int OP_W     = 2;
    localparam int WORKER_W = 2;
    localparam int TASK_W   = 10;
    localparam int STATUS_W = 2;
    localparam int QUEUE_W  = 2;
    localparam int ACTIVE_W = 3;

    localparam int W_BITS    = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
    localparam int ACT_BITS  = $clog2(NUM_WORKERS + 1);
    localparam int POS_BITS  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS  = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOTS     = NUM_WORKERS * QUEUE_DEPTH;
    localparam int ADDR_BITS = $clog2(SLOTS);

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(4);

    typedef enum logic [OP_W-1:0] {
        OP_POST       = 2'd0,
        OP_POST_FRONT = 2'd1,
        OP_FETCH      = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        MEM_NONE  = 2'd0,
        MEM_WRITE = 2'd1,
        MEM_READ  = 2'd2
    } t_mem;

    typedef logic [HANDLE_BITS-1:0] t_handle;
    typedef logic [W_BITS-1:0]      t_qidx;
    typedef logic [POS_BITS-1:0]    t_pos;
    typedef logic [CNT_BITS-1:0]    t_cnt;
    typedef logic [ADDR_BITS-1:0]   t_addr;

    // one classified request, front to back
    typedef struct packed {
        t_status status;
        t_qidx   queue;
        t_addr   addr;
        t_mem    mem;
        logic    stolen;
        t_handle handle;
    } t_cmd;

    // one result word
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [QUEUE_W-1:0]  queue_used;
        logic [TASK_W-1:0]   task_out;
        logic                stolen;
    } t_result;

    function automatic t_pos pos_inc(t_pos p);
        return (int'(p) == QUEUE_DEPTH - 1) ? '0 : POS_BITS'(int'(p) + 1);
    endfunction

    function automatic t_pos pos_dec(t_pos p);
        return (p == '0) ? POS_BITS'(QUEUE_DEPTH - 1) : POS_BITS'(int'(p) - 1);
    endfunction

    // head plus an offset below the depth, wrapped once
    function automatic t_pos pos_add(t_pos head, t_cnt off);
        logic [POS_BITS:0] s;
        s = (POS_BITS+1)'(head) + (POS_BITS+1)'(off);
        if (s >= (POS_BITS+1)'(QUEUE_DEPTH)) begin
            s = s - (POS_BITS+1)'(QUEUE_DEPTH);
        end
        return POS_BITS'(s);
    endfunction

    function automatic t_addr slot_addr(t_qidx q, t_pos p);
        return ADDR_BITS'(int'(q) * QUEUE_DEPTH + int'(p));
    endfunction

endpackage

// File: sv/shortest_queue_work_stealing_dispatch.sv
// ----------------------------------------------------------------------------
// shortest_queue_work_stealing_dispatch
// Join-shortest-queue task dispatcher over per-worker work-stealing deques.
// ----------------------------------------------------------------------------
// Push a request word (op, worker, task handle) while full is low; one result
// word (status, queue used, task, stolen flag) comes out for every request,
// in order, through a two-word result queue read by pop while empty is low.
// The front end classifies a request in its accept cycle: it picks the
// shortest active queue for a plain post, the named queue for a directed
// post, and the own front or the first other non-empty active queue's back
// for a fetch, and updates heads and counts right away. A two-word command
// queue hands the slot access to the back end, which owns the task RAM. A
// post passes through the back end's run state alone; a fetch also needs
// its read state, set by the RAM's registered read, and blocks the next
// command until its word is queued. Posts thus sustain one word per cycle
// while the result queue has room. Slots hold their last written handle; no
// clearing pass runs after reset. Write active_workers through i_cfg_we only while idle.
// ----------------------------------------------------------------------------
module shortest_queue_work_stealing_dispatch (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sqwsd_pkg::ACTIVE_W-1:0] i_cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic [sqwsd_pkg::OP_W-1:0]     i_op,
    input  logic [sqwsd_pkg::WORKER_W-1:0] i_worker,
    input  logic [sqwsd_pkg::TASK_W-1:0]   i_task_handle,
    output logic                           empty,
    input  logic                           pop,
    output logic [sqwsd_pkg::STATUS_W-1:0] o_status,
    output logic [sqwsd_pkg::QUEUE_W-1:0]  o_queue_used,
    output logic [sqwsd_pkg::TASK_W-1:0]   o_task_out,
    output logic                           o_stolen
);
    import sqwsd_pkg::*;

    // command word between the two halves
    logic    cmd_valid;
    logic    cmd_pop;
    t_cmd    cmd;
    t_result result;

    // classify, track occupancy, hold the config register
    sqwsd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_push        (push),
        .o_full        (full),
        .i_op          (i_op),
        .i_worker      (i_worker),
        .i_task_handle (i_task_handle),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .i_cmd_pop     (cmd_pop)
    );

    // access the slots, build and queue result words
    sqwsd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (result)
    );

    assign o_status     = result.status;
    assign o_queue_used = result.queue_used;
    assign o_task_out   = result.task_out;
    assign o_stolen     = result.stolen;

endmodule

// File: sv/sqwsd_ram.sv
// ----------------------------------------------------------------------------
// sqwsd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sqwsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/sqwsd_front.sv
// ----------------------------------------------------------------------------
// sqwsd_front
// Classify requests, keep deque heads and counts, queue commands to the back.
// ----------------------------------------------------------------------------
module sqwsd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sqwsd_pkg::ACTIVE_W-1:0] i_cfg_data,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [sqwsd_pkg::OP_W-1:0]     i_op,
    input  logic [sqwsd_pkg::WORKER_W-1:0] i_worker,
    input  logic [sqwsd_pkg::TASK_W-1:0]   i_task_handle,
    output logic                          o_cmd_valid,
    output sqwsd_pkg::t_cmd               o_cmd,
    input  logic                          i_cmd_pop
);
    import sqwsd_pkg::*;

    typedef struct packed {
        t_qidx q;
        logic  head_en;
        t_pos  head;
        logic  inc;
        logic  dec;
    } t_upd;

    logic [ACTIVE_W-1:0] r_active;
    t_pos                r_head  [NUM_WORKERS];
    t_cnt                r_count [NUM_WORKERS];

    t_cmd       r_fifo [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    t_qidx              w;
    logic [ACT_BITS-1:0] act;
    t_qidx              best;
    t_qidx              victim;
    logic               found;
    t_cmd               n_cmd;
    t_upd               upd;
    logic               accept;
    t_pos               tgt_pos;

    assign o_full      = (r_cnt == 2'd2);
    assign accept      = i_push && !o_full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_fifo[r_rp];

    // worker modulo the queue count, and the live queue count clamped
    always_comb begin
        if (int'(i_worker) >= NUM_WORKERS) begin
            w = W_BITS'(int'(i_worker) - NUM_WORKERS);
        end else begin
            w = W_BITS'(i_worker);
        end
        if (r_active == '0) begin
            act = ACT_BITS'(1);
        end else if (int'(r_active) > NUM_WORKERS) begin
            act = ACT_BITS'(NUM_WORKERS);
        end else begin
            act = ACT_BITS'(r_active);
        end
    end

    // shortest active queue, first one wins a tie
    always_comb begin
        best = '0;
        for (int i = 1; i < NUM_WORKERS; i++) begin
            if (i < int'(act) && r_count[i] < r_count[best]) begin
                best = W_BITS'(i);
            end
        end
    end

    // first non-empty active queue other than the requester's
    always_comb begin
        found  = 1'b0;
        victim = '0;
        for (int i = 0; i < NUM_WORKERS; i++) begin
            if (!found && i < int'(act) && W_BITS'(i) != w && r_count[i] != '0) begin
                found  = 1'b1;
                victim = W_BITS'(i);
            end
        end
    end

    always_comb begin
        n_cmd.status = ST_DONE;
        n_cmd.queue  = w;
        n_cmd.addr   = '0;
        n_cmd.mem    = MEM_NONE;
        n_cmd.stolen = 1'b0;
        n_cmd.handle = HANDLE_BITS'(i_task_handle);
        upd.q        = w;
        upd.head_en  = 1'b0;
        upd.head     = r_head[w];
        upd.inc      = 1'b0;
        upd.dec      = 1'b0;
        tgt_pos      = '0;
        unique case (i_op)
            OP_POST: begin
                n_cmd.queue = best;
                upd.q       = best;
                if (int'(r_count[best]) >= QUEUE_DEPTH) begin
                    n_cmd.status = ST_FULL;
                end else begin
                    tgt_pos    = pos_add(r_head[best], r_count[best]);
                    n_cmd.addr = slot_addr(best, tgt_pos);
                    n_cmd.mem  = MEM_WRITE;
                    upd.inc    = 1'b1;
                end
            end
            OP_POST_FRONT: begin
                if (int'(r_count[w]) >= QUEUE_DEPTH) begin
                    n_cmd.status = ST_FULL;
                end else begin
                    tgt_pos     = pos_dec(r_head[w]);
                    n_cmd.addr  = slot_addr(w, tgt_pos);
                    n_cmd.mem   = MEM_WRITE;
                    upd.head_en = 1'b1;
                    upd.head    = tgt_pos;
                    upd.inc     = 1'b1;
                end
            end
            default: begin
                if (r_count[w] != '0) begin
                    n_cmd.addr  = slot_addr(w, r_head[w]);
                    n_cmd.mem   = MEM_READ;
                    upd.head_en = 1'b1;
                    upd.head    = pos_inc(r_head[w]);
                    upd.dec     = 1'b1;
                end else if (found) begin
                    tgt_pos      = pos_add(r_head[victim], r_count[victim] - CNT_BITS'(1));
                    n_cmd.queue  = victim;
                    n_cmd.addr   = slot_addr(victim, tgt_pos);
                    n_cmd.mem    = MEM_READ;
                    n_cmd.stolen = 1'b1;
                    upd.q        = victim;
                    upd.dec      = 1'b1;
                end else begin
                    n_cmd.status = ST_EMPTY;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RESET;
            r_wp     <= 1'b0;
            r_rp     <= 1'b0;
            r_cnt    <= 2'd0;
            for (int i = 0; i < NUM_WORKERS; i++) begin
                r_head[i]  <= '0;
                r_count[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_active <= i_cfg_data;
            end
            if (accept) begin
                r_fifo[r_wp] <= n_cmd;
                r_wp         <= ~r_wp;
                if (upd.head_en) begin
                    r_head[upd.q] <= upd.head;
                end
                if (upd.inc) begin
                    r_count[upd.q] <= r_count[upd.q] + CNT_BITS'(1);
                end else if (upd.dec) begin
                    r_count[upd.q] <= r_count[upd.q] - CNT_BITS'(1);
                end
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, accept} - {1'b0, i_cmd_pop};
        end
    end

endmodule

// File: sv/sqwsd_back.sv
// ----------------------------------------------------------------------------
// sqwsd_back
// Execute slot writes and reads on the task RAM, queue result words.
// ----------------------------------------------------------------------------
module sqwsd_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cmd_valid,
    input  sqwsd_pkg::t_cmd              i_cmd,
    output logic                         o_cmd_pop,
    output logic                         o_empty,
    input  logic                         i_pop,
    output sqwsd_pkg::t_result           o_result
);
    import sqwsd_pkg::*;

    typedef enum logic {
        S_RUN  = 1'b0,
        S_READ = 1'b1
    } t_state;

    t_state  r_state, n_state;
    t_cmd    r_pend, n_pend;
    t_result r_res [2];
    logic    r_wp;
    logic    r_rp;
    logic [1:0] r_res_cnt;

    logic    ram_we;
    logic    ram_re;
    t_handle ram_rdata;
    logic    res_push;
    logic    res_pop;
    t_result res_word;

    sqwsd_ram #(
        .WIDTH (HANDLE_BITS),
        .DEPTH (SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_cmd.addr),
        .i_wdata (i_cmd.handle),
        .i_re    (ram_re),
        .i_raddr (i_cmd.addr),
        .o_rdata (ram_rdata)
    );

    assign o_empty  = (r_res_cnt == 2'd0);
    assign res_pop  = i_pop && !o_empty;
    assign o_result = r_res[r_rp];

    always_comb begin
        n_state   = r_state;
        n_pend    = r_pend;
        o_cmd_pop = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        res_push  = 1'b0;
        res_word.status     = i_cmd.status;
        res_word.queue_used = QUEUE_W'(i_cmd.queue);
        res_word.task_out   = '0;
        res_word.stolen     = i_cmd.stolen;
        unique case (r_state)
            S_RUN: begin
                if (i_cmd_valid && r_res_cnt != 2'd2) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.mem)
                        MEM_READ: begin
                            ram_re  = 1'b1;
                            n_pend  = i_cmd;
                            n_state = S_READ;
                        end
                        MEM_WRITE: begin
                            ram_we   = 1'b1;
                            res_push = 1'b1;
                        end
                        default: begin
                            res_push = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                // return the slot read last cycle
                res_push            = 1'b1;
                res_word.status     = r_pend.status;
                res_word.queue_used = QUEUE_W'(r_pend.queue);
                res_word.task_out   = TASK_W'(ram_rdata);
                res_word.stolen     = r_pend.stolen;
                n_state             = S_RUN;
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_RUN;
            r_wp      <= 1'b0;
            r_rp      <= 1'b0;
            r_res_cnt <= 2'd0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            if (res_push) begin
                r_res[r_wp] <= res_word;
                r_wp        <= ~r_wp;
            end
            if (res_pop) begin
                r_rp <= ~r_rp;
            end
            r_res_cnt <= r_res_cnt + {1'b0, res_push} - {1'b0, res_pop};
        end
    end

    a_res_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_cnt != 2'd3)
        else $error("result queue overflow");

    a_read_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> $past(ram_re))
        else $error("read state without a RAM read");

    a_read_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |=> (r_res_cnt != 2'd2))
        else $error("no room for pending read word");

endmodule
